@@ design/epc_pkg.sv @@
// Shared constants, types and the month table for the epoch to calendar unit.
`timescale 1ns / 1ps

package epc_pkg;

  // Reciprocals for division by a constant: q = (x * RECIP) >> SHIFT is exact over
  // the range of x that reaches each divider.
  localparam logic [31:0] RECIP_SEC  = 32'd2290649225;  // divide by 60, x < 2^32
  localparam int unsigned SHIFT_SEC  = 37;
  localparam logic [26:0] RECIP_MIN  = 27'd71582789;    // divide by 60, x < 2^27
  localparam int unsigned SHIFT_MIN  = 32;
  localparam logic [21:0] RECIP_HOUR = 22'd2796203;     // divide by 24, x < 2^21
  localparam int unsigned SHIFT_HOUR = 26;
  localparam logic [16:0] RECIP_WEEK = 17'd74899;       // divide by 7, x < 2^16
  localparam int unsigned SHIFT_WEEK = 19;
  localparam logic [16:0] RECIP_QUAD = 17'd91868;       // divide by 1461, x < 2^16
  localparam int unsigned SHIFT_QUAD = 27;

  // Calendar constants.
  localparam logic [15:0] WEEKDAY_BIAS  = 16'd4;      // 1970-01-01 was a Thursday
  localparam logic [15:0] DAYS_OF_1969  = 16'd365;    // count days from 1969-01-01
  localparam logic [15:0] SKIP_DAY_FROM = 16'd47541;  // 2100-03-01, days since 1970
  localparam logic [10:0] QUAD_DAYS     = 11'd1461;
  localparam logic [10:0] YEAR_DAYS     = 11'd365;

  // Time-of-day fields that ride along with the date work.
  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [2:0] weekday;
  } epc_tod_t;

  // Beat passed from the time-of-day split to the date split.
  typedef struct packed {
    logic       valid;
    epc_tod_t   tod;
    logic [15:0] quad_days;  // days since 1969-01-01, with a 2100 leap day inserted
  } epc_mid_t;

  // First day of the year of month index idx (0 is January).
  function automatic logic [8:0] month_start(input logic [3:0] idx, input logic leap);
    logic [8:0] base;
    case (idx)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (leap && (idx >= 4'd2)) begin
      base = 9'(base + 9'd1);
    end
    return base;
  endfunction

endpackage

@@ design/epc_if.sv @@
// Handshake channels for the epoch value and the calendar result.
`timescale 1ns / 1ps

interface epc_stamp_if;
  logic        valid;
  logic        ready;
  logic [31:0] epoch_seconds;

  modport source(output valid, output epoch_seconds, input ready);
  modport sink(input valid, input epoch_seconds, output ready);
endinterface

interface epc_date_if;
  logic       valid;
  logic       ready;
  logic [5:0] second_of_minute;
  logic [5:0] minute_of_hour;
  logic [4:0] hour_of_day;
  logic [2:0] weekday;
  logic [7:0] year_offset;
  logic [3:0] month_number;
  logic [4:0] day_of_month;

  modport source(output valid, output second_of_minute, output minute_of_hour,
                 output hour_of_day, output weekday, output year_offset,
                 output month_number, output day_of_month, input ready);
  modport sink(input valid, input second_of_minute, input minute_of_hour,
               input hour_of_day, input weekday, input year_offset,
               input month_number, input day_of_month, output ready);
endinterface

@@ design/epc_clock_split.sv @@
// Five-stage split of the seconds count into second, minute, hour, weekday and day count.
`timescale 1ns / 1ps

module epc_clock_split
  import epc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  logic        stamp_valid,
  input  logic [31:0] epoch_seconds,
  output epc_mid_t    mid
);

  // Stage 1: whole minutes.
  logic        s1_valid;
  logic [31:0] s1_t;
  logic [26:0] s1_q1;
  logic [63:0] p1;

  // Stage 2: second, whole hours.
  logic        s2_valid;
  logic [5:0]  s2_sec;
  logic [5:0]  s2_q1lo;
  logic [20:0] s2_q2;
  logic [52:0] p2;

  // Stage 3: minute, whole days.
  logic        s3_valid;
  logic [5:0]  s3_sec;
  logic [5:0]  s3_min;
  logic [4:0]  s3_q2lo;
  logic [15:0] s3_days;
  logic [42:0] p3;

  // Stage 4: hour, whole weeks, shifted day count.
  logic        s4_valid;
  logic [5:0]  s4_sec;
  logic [5:0]  s4_min;
  logic [4:0]  s4_hour;
  logic [2:0]  s4_wklo;
  logic [2:0]  s4_wqlo;
  logic [15:0] s4_qd;
  logic [15:0] wk_days;
  logic [32:0] p4;

  // Stage 5: weekday.
  logic        s5_valid;
  epc_tod_t    s5_tod;
  logic [15:0] s5_qd;

  // Reciprocal products, one per divider.
  always_comb begin
    p1      = 64'(epoch_seconds) * 64'(RECIP_SEC);
    p2      = 53'(s1_q1) * 53'(RECIP_MIN);
    p3      = 43'(s2_q2) * 43'(RECIP_HOUR);
    wk_days = 16'(s3_days + WEEKDAY_BIAS);
    p4      = 33'(wk_days) * 33'(RECIP_WEEK);
  end

  // Valid bits advance with the data and clear on reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= stamp_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
    end
  end

  // Payload registers; remainders only need the low bits of each quotient.
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_t    <= epoch_seconds;
      s1_q1   <= p1[SHIFT_SEC+26:SHIFT_SEC];

      s2_sec  <= 6'(s1_t[5:0] - 6'(s1_q1[5:0] * 6'd60));
      s2_q1lo <= s1_q1[5:0];
      s2_q2   <= p2[SHIFT_MIN+20:SHIFT_MIN];

      s3_sec  <= s2_sec;
      s3_min  <= 6'(s2_q1lo - 6'(s2_q2[5:0] * 6'd60));
      s3_q2lo <= s2_q2[4:0];
      s3_days <= p3[SHIFT_HOUR+15:SHIFT_HOUR];

      s4_sec  <= s3_sec;
      s4_min  <= s3_min;
      s4_hour <= 5'(s3_q2lo - 5'(s3_days[4:0] * 5'd24));
      s4_wklo <= wk_days[2:0];
      s4_wqlo <= p4[SHIFT_WEEK+2:SHIFT_WEEK];
      // Pretend 2100 is a leap year by skipping its missing 29 February.
      if (s3_days >= SKIP_DAY_FROM) begin
        s4_qd <= 16'(s3_days + DAYS_OF_1969 + 16'd1);
      end else begin
        s4_qd <= 16'(s3_days + DAYS_OF_1969);
      end

      s5_tod.second  <= s4_sec;
      s5_tod.minute  <= s4_min;
      s5_tod.hour    <= s4_hour;
      s5_tod.weekday <= 3'(3'(s4_wklo - 3'(s4_wqlo * 3'd7)) + 3'd1);
      s5_qd          <= s4_qd;
    end
  end

  assign mid.valid     = s5_valid;
  assign mid.tod       = s5_tod;
  assign mid.quad_days = s5_qd;

endmodule

@@ design/epc_date_split.sv @@
// Five-stage split of the day count into year offset, month and day of month.
`timescale 1ns / 1ps

module epc_date_split
  import epc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  epc_mid_t   mid,
  output logic       date_valid,
  output epc_tod_t   tod,
  output logic [7:0] year_offset,
  output logic [3:0] month_number,
  output logic [4:0] day_of_month
);

  // Stage 1: four-year block number.
  logic        d1_valid;
  epc_tod_t    d1_tod;
  logic [15:0] d1_days;
  logic [5:0]  d1_n;
  logic [32:0] p5;

  // Stage 2: day within the block.
  logic        d2_valid;
  epc_tod_t    d2_tod;
  logic [5:0]  d2_n;
  logic [10:0] d2_r;

  // Stage 3: year within the block and day of year.
  logic        d3_valid;
  epc_tod_t    d3_tod;
  logic [7:0]  d3_year;
  logic [8:0]  d3_doy;
  logic        d3_leap;
  logic [1:0]  yb;
  logic [10:0] yb_start;

  // Stage 4: month index.
  logic        d4_valid;
  epc_tod_t    d4_tod;
  logic [7:0]  d4_year;
  logic [8:0]  d4_doy;
  logic        d4_leap;
  logic [3:0]  d4_mi;
  logic [3:0]  mi;

  // Stage 5: output register.
  logic        d5_valid;
  epc_tod_t    d5_tod;
  logic [7:0]  d5_year;
  logic [3:0]  d5_month;
  logic [4:0]  d5_day;

  assign p5 = 33'(mid.quad_days) * 33'(RECIP_QUAD);

  // Year within the block: the last year of each block holds the leap day.
  always_comb begin
    if (d2_r >= 11'(3 * YEAR_DAYS)) begin
      yb       = 2'd3;
      yb_start = 11'(3 * YEAR_DAYS);
    end else if (d2_r >= 11'(2 * YEAR_DAYS)) begin
      yb       = 2'd2;
      yb_start = 11'(2 * YEAR_DAYS);
    end else if (d2_r >= YEAR_DAYS) begin
      yb       = 2'd1;
      yb_start = YEAR_DAYS;
    end else begin
      yb       = 2'd0;
      yb_start = 11'd0;
    end
  end

  // Month index: the last month whose first day is not after the day of year.
  always_comb begin
    mi = 4'd0;
    for (int k = 1; k < 12; k++) begin
      if (d3_doy >= month_start(4'(k), d3_leap)) begin
        mi = 4'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d1_valid <= 1'b0;
      d2_valid <= 1'b0;
      d3_valid <= 1'b0;
      d4_valid <= 1'b0;
      d5_valid <= 1'b0;
    end else if (advance) begin
      d1_valid <= mid.valid;
      d2_valid <= d1_valid;
      d3_valid <= d2_valid;
      d4_valid <= d3_valid;
      d5_valid <= d4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      d1_tod   <= mid.tod;
      d1_days  <= mid.quad_days;
      d1_n     <= p5[SHIFT_QUAD+5:SHIFT_QUAD];

      d2_tod   <= d1_tod;
      d2_n     <= d1_n;
      d2_r     <= 11'(d1_days[10:0] - 11'(d1_n * QUAD_DAYS));

      // Blocks start in 1969, so the offset from 1970 is one less.
      d3_tod   <= d2_tod;
      d3_year  <= 8'(8'({d2_n, 2'b00}) + 8'(yb) - 8'd1);
      d3_doy   <= 9'(d2_r - yb_start);
      d3_leap  <= (yb == 2'd3);

      d4_tod   <= d3_tod;
      d4_year  <= d3_year;
      d4_doy   <= d3_doy;
      d4_leap  <= d3_leap;
      d4_mi    <= mi;

      d5_tod   <= d4_tod;
      d5_year  <= d4_year;
      d5_month <= 4'(d4_mi + 4'd1);
      d5_day   <= 5'(d4_doy - month_start(d4_mi, d4_leap) + 9'd1);
    end
  end

  assign date_valid   = d5_valid;
  assign tod          = d5_tod;
  assign year_offset  = d5_year;
  assign month_number = d5_month;
  assign day_of_month = d5_day;

endmodule

@@ design/epoch_to_calendar_unit.sv @@
// Top level of the epoch to calendar unit: two pipelined halves under one stall.
`timescale 1ns / 1ps

// Converts an unsigned 32-bit count of seconds since 1970-01-01 00:00:00 into second,
// minute, hour, weekday (1 is Sunday), year offset from 1970, month and day of month.
// The unit is a ten-stage pipeline, and one beat can enter every cycle while result beats
// are taken. The depth comes from the chain of reciprocal multiplications (by 1/60,
// 1/60, 1/24, 1/7 and 1/1461), each followed by a register, then the year and month
// selection. When the result beat is not taken, the whole pipeline holds and ready on
// the input side drops. Leap years follow the Gregorian rule, so 2100 is a common year.
// No state is kept between beats.

module epoch_to_calendar_unit
  import epc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  epc_stamp_if.sink  stamp,
  epc_date_if.source date
);

  logic       advance;
  epc_mid_t   mid;
  epc_tod_t   tod;
  logic       date_valid;
  logic [7:0] year_offset;
  logic [3:0] month_number;
  logic [4:0] day_of_month;

  // The pipeline moves whenever the output register is empty or being drained.
  assign advance     = !date_valid || date.ready;
  assign stamp.ready = advance;

  epc_clock_split u_clock (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .stamp_valid   (stamp.valid),
    .epoch_seconds (stamp.epoch_seconds),
    .mid           (mid)
  );

  epc_date_split u_date (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .mid          (mid),
    .date_valid   (date_valid),
    .tod          (tod),
    .year_offset  (year_offset),
    .month_number (month_number),
    .day_of_month (day_of_month)
  );

  assign date.valid            = date_valid;
  assign date.second_of_minute = tod.second;
  assign date.minute_of_hour   = tod.minute;
  assign date.hour_of_day      = tod.hour;
  assign date.weekday          = tod.weekday;
  assign date.year_offset      = year_offset;
  assign date.month_number     = month_number;
  assign date.day_of_month     = day_of_month;

`ifndef NO_ASSERTIONS
  // Time of day and weekday from the reciprocal dividers stay in range.
  a_tod_range: assert property (@(posedge clk) disable iff (rst)
    date_valid |-> (tod.second < 6'd60) && (tod.minute < 6'd60) &&
                   (tod.hour < 5'd24) && (tod.weekday != 3'd0))
    else $error("time of day out of range");

  // February never runs past its 29th day.
  a_feb_len: assert property (@(posedge clk) disable iff (rst)
    date_valid && (month_number == 4'd2) |-> (day_of_month <= 5'd29))
    else $error("February day out of range");

  // A 29 February lands only in a leap year, and 2100 is not one.
  a_leap_day: assert property (@(posedge clk) disable iff (rst)
    date_valid && (month_number == 4'd2) && (day_of_month == 5'd29) |->
      (year_offset[1:0] == 2'd2) && (year_offset != 8'd130))
    else $error("29 February in a common year");

  // Thirty-day months, the month range and a nonzero day.
  a_month_len: assert property (@(posedge clk) disable iff (rst)
    date_valid |-> (month_number != 4'd0) && (month_number <= 4'd12) &&
      (day_of_month != 5'd0) &&
      (!((month_number == 4'd4) || (month_number == 4'd6) ||
         (month_number == 4'd9) || (month_number == 4'd11)) ||
       (day_of_month <= 5'd30)))
    else $error("day of month out of range");
`endif

endmodule

@@ dv/epoch_to_calendar_unit_tb.sv @@
// Self-checking testbench for the epoch to calendar unit, with its own calendar predictor.
`timescale 1ns / 1ps

module epoch_to_calendar_unit_tb;
  import epc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 30;
  localparam int unsigned RANDOM_BEATS = 800;
  localparam int unsigned DAY_SECONDS  = 86400;

  // Broken-down calendar fields at the widths of the result channel.
  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [2:0] weekday;
    logic [7:0] year_offset;
    logic [3:0] month;
    logic [4:0] day;
  } date_fields_t;

  localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  logic clk;
  logic rst;

  epc_stamp_if stamp_ch ();
  epc_date_if  date_ch ();

  epoch_to_calendar_unit uut (
    .clk   (clk),
    .rst   (rst),
    .stamp (stamp_ch),
    .date  (date_ch)
  );

  date_fields_t expected_dates [$];
  int unsigned  mismatches = 0;
  int unsigned  cycle_count = 0;
  int unsigned  stall_left = 0;
  bit           calm = 1'b0;

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop if the run hangs.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("epoch_to_calendar_unit: mismatch");
    $finish;
  end

  // Gregorian rule on an offset from 1970.
  function automatic bit is_leap_offset(int unsigned offset);
    int unsigned y;
    y = 1970 + offset;
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  // Split an epoch count into calendar fields by stepping over years and months.
  function automatic date_fields_t calendar_of(logic [31:0] secs);
    date_fields_t d;
    int unsigned  t, days, year, year_len, month;
    int unsigned  lens [12];
    t = secs;
    d.second = 6'(t % 60);
    t = t / 60;
    d.minute = 6'(t % 60);
    t = t / 60;
    d.hour = 5'(t % 24);
    days = t / 24;
    d.weekday = 3'(((days + 4) % 7) + 1);
    year = 0;
    year_len = is_leap_offset(0) ? 366 : 365;
    while (days >= year_len) begin
      days -= year_len;
      year++;
      year_len = is_leap_offset(year) ? 366 : 365;
    end
    lens = MONTH_DAYS;
    if (is_leap_offset(year)) begin
      lens[1] = 29;
    end
    month = 0;
    while (month < 11 && days >= lens[month]) begin
      days -= lens[month];
      month++;
    end
    d.year_offset = 8'(year);
    d.month = 4'(month + 1);
    d.day = 5'(days + 1);
    return d;
  endfunction

  // Idle length: mostly none, some short, a few long.
  function automatic int unsigned pick_idle();
    int unsigned r;
    if (calm) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Result side stalls at random.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      date_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      date_ch.ready <= 1'b1;
      stall_left <= pick_idle();
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Compare every accepted result beat with the oldest prediction.
  always @(posedge clk) begin
    date_fields_t want;
    if (!rst && date_ch.valid && date_ch.ready) begin
      if (expected_dates.size() == 0) begin
        $error("result beat with no prediction pending");
        mismatches++;
      end else begin
        want = expected_dates.pop_front();
        check_field("second_of_minute", want.second, date_ch.second_of_minute);
        check_field("minute_of_hour", want.minute, date_ch.minute_of_hour);
        check_field("hour_of_day", want.hour, date_ch.hour_of_day);
        check_field("weekday", want.weekday, date_ch.weekday);
        check_field("year_offset", want.year_offset, date_ch.year_offset);
        check_field("month_number", want.month, date_ch.month_number);
        check_field("day_of_month", want.day, date_ch.day_of_month);
      end
    end
  end

  // Send one epoch beat, record its prediction, then maybe idle.
  task automatic send_stamp(input logic [31:0] secs);
    int unsigned gap;
    stamp_ch.valid <= 1'b1;
    stamp_ch.epoch_seconds <= secs;
    @(posedge clk);
    while (!stamp_ch.ready) begin
      @(posedge clk);
    end
    expected_dates.push_back(calendar_of(secs));
    gap = pick_idle();
    if (gap != 0) begin
      stamp_ch.valid <= 1'b0;
      stamp_ch.epoch_seconds <= $urandom();
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid once the last beat has gone, unless an idle gap already did.
  task automatic park_stamp();
    if (stamp_ch.valid) begin
      stamp_ch.valid <= 1'b0;
    end
  endtask

  task automatic wait_all_dates();
    while (expected_dates.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Field extremes, alternating bit patterns and the first days of the epoch.
  task automatic test_field_extremes();
    send_stamp(32'd0);
    send_stamp(32'hFFFF_FFFF);
    send_stamp(32'h5555_5555);
    send_stamp(32'hAAAA_AAAA);
    send_stamp(32'd59);
    send_stamp(32'd60);
    send_stamp(32'd3599);
    send_stamp(32'd3600);
    send_stamp(32'd86399);
    send_stamp(32'd86400);
    send_stamp(32'd172800);
    send_stamp(32'd259200);
    send_stamp(32'h7FFF_FFFF);
    send_stamp(32'h8000_0000);
  endtask

  // Leap days, year ends, and 2100 as a century that is not a leap year.
  task automatic test_calendar_boundaries();
    send_stamp(32'd68169600);
    send_stamp(32'd94694399);
    send_stamp(32'd94694400);
    send_stamp(32'd946684799);
    send_stamp(32'd951782400);
    send_stamp(32'd951868799);
    send_stamp(32'd951868800);
    send_stamp(32'd978220800);
    send_stamp(32'd4102444799);
    send_stamp(32'd4107456000);
    send_stamp(32'd4107542399);
    send_stamp(32'd4107542400);
  endtask

  // The sender stops until the pipeline is empty, then resumes back to back.
  task automatic test_drained_restart();
    calm = 1'b1;
    repeat (10) send_stamp($urandom());
    park_stamp();
    wait_all_dates();
    repeat (10) send_stamp($urandom());
    calm = 1'b0;
  endtask

  // Random stamps: uniform values, edges of a day, and days around year ends and February.
  task automatic test_random_stamps(int unsigned count);
    longint      secs;
    int unsigned yoff, start_day, k;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 50 == 0) begin
        calm = ($urandom_range(0, 3) == 0);
      end
      case ($urandom_range(0, 2))
        0: begin
          secs = $urandom();
        end
        1: begin
          secs = longint'($urandom_range(0, 49709)) * DAY_SECONDS;
          secs += $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(86396, 86399);
        end
        default: begin
          yoff = $urandom_range(1, 135);
          start_day = 0;
          for (k = 0; k < yoff; k++) begin
            start_day += is_leap_offset(k) ? 366 : 365;
          end
          case ($urandom_range(0, 4))
            0: start_day = start_day - 1;
            1: start_day = start_day;
            2: start_day = start_day + 58;
            3: start_day = start_day + 59;
            default: start_day = start_day + 60;
          endcase
          secs = longint'(start_day) * DAY_SECONDS + $urandom_range(0, DAY_SECONDS - 1);
        end
      endcase
      send_stamp(32'(secs));
    end
    calm = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    stamp_ch.valid = 1'b0;
    stamp_ch.epoch_seconds = '0;
    date_ch.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_field_extremes();
    test_calendar_boundaries();
    test_drained_restart();
    test_random_stamps(RANDOM_BEATS);
    park_stamp();

    // Let the pipeline empty, then watch for stray beats.
    wait_all_dates();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("epoch_to_calendar_unit: match");
    end else begin
      $display("epoch_to_calendar_unit: mismatch");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/epc_pkg.sv
design/epc_if.sv
design/epc_clock_split.sv
design/epc_date_split.sv
design/epoch_to_calendar_unit.sv
dv/epoch_to_calendar_unit_tb.sv
